### rtl/core/cqia_pkg.sv
// shared types, constants and ring helpers for the circular queue with indexed access
// no dependencies; used by cqia_store, cqia_ctrl and the top level
package cqia_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int POS_W  = 4;
   localparam int STAT_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH     = 3'd0,
      CMD_POP      = 3'd1,
      CMD_RD_FRONT = 3'd2,
      CMD_RD_BACK  = 3'd3,
      CMD_RD_AT    = 3'd4,
      CMD_WR_AT    = 3'd5,
      CMD_FIND     = 3'd6,
      CMD_CLEAR    = 3'd7
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_RANGE    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [POS_W-1:0]         fpos;
      status_type               status;
      logic [CNT_W-1:0]         entries;
   } res_type;

   // slot of the entry at offset off from base, wrapping at the depth
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] off);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (ADDR_W+1)'(DEPTH)) begin
         sum = sum - (ADDR_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // next slot, wrapping at the depth
   function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] slot);
      logic [ADDR_W-1:0] res;
      if (slot == ADDR_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = slot + ADDR_W'(1);
      end
      return res;
   endfunction

endpackage

### rtl/core/cqia_store.sv
// slot memory of the queue: one write port, one read port with registered data
// depends on cqia_pkg for depth and widths
module cqia_store (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [cqia_pkg::ADDR_W-1:0]          wr_addr,
   input  logic signed [cqia_pkg::DATA_W-1:0]   wr_data,
   input  logic [cqia_pkg::ADDR_W-1:0]          rd_addr,
   output logic signed [cqia_pkg::DATA_W-1:0]   rd_data
);

   logic signed [cqia_pkg::DATA_W-1:0] mem [cqia_pkg::DEPTH];
   logic signed [cqia_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cqia_ctrl.sv
// command sequencer: pointers, fill count, shared ring adder and the find scan
// depends on cqia_pkg; drives the slot memory in cqia_store
module cqia_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cqia_pkg::CMD_W-1:0]           req_command,
   input  logic [cqia_pkg::POS_W-1:0]           req_position,
   input  logic signed [cqia_pkg::DATA_W-1:0]   req_data_in,
   output logic                                 wr_en,
   output logic [cqia_pkg::ADDR_W-1:0]          wr_addr,
   output logic signed [cqia_pkg::DATA_W-1:0]   wr_data,
   output logic [cqia_pkg::ADDR_W-1:0]          rd_addr,
   input  logic signed [cqia_pkg::DATA_W-1:0]   rd_data,
   output logic                                 res_valid,
   output cqia_pkg::res_type                    res,
   input  logic                                 res_take
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [cqia_pkg::ADDR_W-1:0]        head_ff, head_in;
   logic [cqia_pkg::ADDR_W-1:0]        tail_ff, tail_in;
   logic [cqia_pkg::CNT_W-1:0]         fill_ff, fill_in;
   logic [cqia_pkg::ADDR_W-1:0]        idx_ff, idx_in;
   logic signed [cqia_pkg::DATA_W-1:0] key_ff, key_in;
   cqia_pkg::res_type                  res_ff, res_in;

   logic [cqia_pkg::ADDR_W-1:0]        ring_off;
   logic [cqia_pkg::ADDR_W-1:0]        ring_out;
   logic [cqia_pkg::ADDR_W-1:0]        tail_inc;
   logic                               pos_bad;
   logic                               is_empty;

   // the one ring adder, shared by read at, write at and every scan step
   assign ring_out = cqia_pkg::ring_add(head_ff, ring_off);
   assign tail_inc = cqia_pkg::ring_inc(tail_ff);
   assign pos_bad  = 32'(req_position) >= 32'(fill_ff);
   assign is_empty = fill_ff == '0;

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = ring_out;
      wr_data  = req_data_in;
      ring_off = cqia_pkg::ADDR_W'(req_position);
      rd_addr  = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in         = req_data_in;
               res_in.data    = '0;
               res_in.fpos    = '0;
               res_in.status  = cqia_pkg::ST_OK;
               res_in.entries = fill_ff;
               state_in       = S_DONE;
               unique case (cqia_pkg::cmd_type'(req_command))
                  cqia_pkg::CMD_PUSH: begin
                     if (fill_ff == cqia_pkg::CNT_W'(cqia_pkg::DEPTH)) begin
                        res_in.status = cqia_pkg::ST_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        wr_addr        = tail_inc;
                        tail_in        = tail_inc;
                        fill_in        = fill_ff + cqia_pkg::CNT_W'(1);
                        res_in.entries = fill_ff + cqia_pkg::CNT_W'(1);
                     end
                  end
                  cqia_pkg::CMD_POP: begin
                     if (is_empty) begin
                        res_in.status = cqia_pkg::ST_EMPTY;
                     end else begin
                        head_in        = cqia_pkg::ring_inc(head_ff);
                        fill_in        = fill_ff - cqia_pkg::CNT_W'(1);
                        res_in.entries = fill_ff - cqia_pkg::CNT_W'(1);
                     end
                  end
                  cqia_pkg::CMD_RD_FRONT: begin
                     if (is_empty) begin
                        res_in.status = cqia_pkg::ST_EMPTY;
                     end else begin
                        rd_addr  = head_ff;
                        state_in = S_READ;
                     end
                  end
                  cqia_pkg::CMD_RD_BACK: begin
                     if (is_empty) begin
                        res_in.status = cqia_pkg::ST_EMPTY;
                     end else begin
                        rd_addr  = tail_ff;
                        state_in = S_READ;
                     end
                  end
                  cqia_pkg::CMD_RD_AT: begin
                     if (pos_bad) begin
                        res_in.status = cqia_pkg::ST_RANGE;
                     end else begin
                        rd_addr  = ring_out;
                        state_in = S_READ;
                     end
                  end
                  cqia_pkg::CMD_WR_AT: begin
                     if (pos_bad) begin
                        res_in.status = cqia_pkg::ST_RANGE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = ring_out;
                     end
                  end
                  cqia_pkg::CMD_FIND: begin
                     if (is_empty) begin
                        res_in.status = cqia_pkg::ST_NOTFOUND;
                     end else begin
                        rd_addr  = head_ff;
                        idx_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  cqia_pkg::CMD_CLEAR: begin
                     head_in        = '0;
                     tail_in        = cqia_pkg::ADDR_W'(cqia_pkg::DEPTH - 1);
                     fill_in        = '0;
                     res_in.entries = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            res_in.data = rd_data;
            state_in    = S_DONE;
         end
         S_SCAN: begin
            // word of entry idx is here now; fetch entry idx+1 behind it
            ring_off = idx_ff + cqia_pkg::ADDR_W'(1);
            rd_addr  = ring_out;
            if (rd_data == key_ff) begin
               res_in.fpos = cqia_pkg::POS_W'(idx_ff);
               state_in    = S_DONE;
            end else if (cqia_pkg::CNT_W'(idx_ff) + cqia_pkg::CNT_W'(1) == fill_ff) begin
               res_in.status = cqia_pkg::ST_NOTFOUND;
               state_in      = S_DONE;
            end else begin
               idx_in = idx_ff + cqia_pkg::ADDR_W'(1);
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= cqia_pkg::ADDR_W'(cqia_pkg::DEPTH - 1);
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
      idx_ff <= idx_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign res_valid = state_ff == S_DONE;
   assign res       = res_ff;

endmodule

### rtl/core/circular_queue_with_indexed_access.sv
// top level of the circular queue with indexed access
// depends on cqia_pkg, cqia_store and cqia_ctrl
//
// A fixed-depth ring of 16 signed 32-bit words, driven one command per req
// beat: push, pop, read front, read back, read at a position from the front,
// write at a position, find the first position holding a value, and clear.
// Every command gives exactly one rsp beat with the word read, the found
// position, a status code and the number of entries held afterwards; failed
// commands leave the queue untouched. The block takes one command at a time.
// Push, pop, write at, clear and every failing command go straight from
// acceptance to the done state; the reads pass a read state first, since the
// slot memory has a registered read port. Find walks the entries from the
// front through the same read port and one comparator, one entry per cycle,
// until the first match or the last entry. The finished rsp beat sits in an
// output register, so the next command is taken while it waits for the
// receiver. No clearing pass is needed after reset: slots are only read below
// the fill count, and each of those has been written.
module circular_queue_with_indexed_access (
   input  logic                                 clock,
   input  logic                                 reset,
   // command channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cqia_pkg::CMD_W-1:0]           req_command,
   input  logic [cqia_pkg::POS_W-1:0]           req_position,
   input  logic signed [cqia_pkg::DATA_W-1:0]   req_data_in,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [cqia_pkg::DATA_W-1:0]   rsp_data_out,
   output logic [cqia_pkg::POS_W-1:0]           rsp_found_position,
   output logic [cqia_pkg::STAT_W-1:0]          rsp_status,
   output logic [cqia_pkg::CNT_W-1:0]           rsp_entries
);

   // memory ports between sequencer and slot store
   logic                               wr_en;
   logic [cqia_pkg::ADDR_W-1:0]        wr_addr;
   logic signed [cqia_pkg::DATA_W-1:0] wr_data;
   logic [cqia_pkg::ADDR_W-1:0]        rd_addr;
   logic signed [cqia_pkg::DATA_W-1:0] rd_data;

   // finished result from the sequencer
   logic                               res_valid;
   cqia_pkg::res_type                  res;
   logic                               res_take;

   // rsp output register
   logic                               rsp_valid_ff, rsp_valid_in;
   cqia_pkg::res_type                  rsp_res_ff, rsp_res_in;

   cqia_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cqia_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_position (req_position),
      .req_data_in  (req_data_in),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .res_valid    (res_valid),
      .res          (res),
      .res_take     (res_take)
   );

   // move the result across once the output register is empty or draining
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = rsp_res_ff.data;
   assign rsp_found_position = rsp_res_ff.fpos;
   assign rsp_status         = rsp_res_ff.status;
   assign rsp_entries        = rsp_res_ff.entries;

   // a command is never taken back to back with its own acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("command accepted while previous one still in progress");

   // the reported count never passes the depth
   a_entries_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_entries) <= cqia_pkg::DEPTH)
      else $error("entry count beyond depth");

   // a full report only comes from a full queue
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cqia_pkg::ST_FULL
         |-> 32'(rsp_entries) == cqia_pkg::DEPTH)
      else $error("full status with spare room");

   // read data and found position are zero unless the command succeeded
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cqia_pkg::ST_OK
         |-> rsp_data_out == '0 && rsp_found_position == '0)
      else $error("payload not cleared on failing command");

endmodule
